### src/hlcd_pkg.sv
`default_nettype none

package hlcd_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TABLE_BITS_DEF = 6;

    // Fixed field widths
    localparam int BASE_W  = 17;
    localparam int TS_W    = 64;
    localparam int HL_W    = 32;
    localparam int WHOLE_W = 5;              // whole part of elapsed/half-life, below 17
    localparam int WHOLE_LIMIT = 17;         // whole part at which the result is zero
    localparam int ELAPSED_W   = HL_W + WHOLE_W;  // elapsed below 17*half-life fits here
    localparam int SHIFT_W     = 6;          // Q_SHIFT + whole part

    // 2^-f table, Q30
    localparam int Q_SHIFT      = 30;
    localparam int ENTRY_W      = Q_SHIFT + 1;
    localparam int TAB_MAX_BITS = 10;
    localparam int TAB_MAX_LEN  = (1 << TAB_MAX_BITS) + 1;
    localparam int TAB_IDX_W    = TAB_MAX_BITS + 1;

    typedef logic [ENTRY_W-1:0] tab_entry_t;
    typedef tab_entry_t tab_t [TAB_MAX_LEN];

    // Per-word flags that ride alongside the divider and the multiply stages
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              apply;   // decay computed
        logic              big;     // whole part 17 or more
    } side_t;

    // Integer square root, 64-bit operand, 32-bit root
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Table of 2^-(i/2^tb) in Q30 with 2^tb+1 live entries, built at elaboration
    function automatic tab_t build_tab(input int tb);
        logic [63:0] c [TAB_MAX_BITS+1];
        logic [63:0] e;
        tab_t        t;
        for (int k = 0; k <= TAB_MAX_BITS; k++) begin
            c[k] = '0;
        end
        c[0] = 64'd1 << (Q_SHIFT - 1);
        c[1] = int_sqrt(64'd1 << (2 * Q_SHIFT - 1));
        for (int k = 2; k <= tb; k++) begin
            c[k] = int_sqrt(c[k-1] << Q_SHIFT);
        end
        for (int i = 0; i < TAB_MAX_LEN; i++) begin
            t[i] = '0;
        end
        for (int i = 0; i < (1 << tb); i++) begin
            e = 64'd1 << Q_SHIFT;
            for (int j = 0; j < tb; j++) begin
                if (((i >> j) & 1) != 0) begin
                    e = (e * c[tb-j]) >> Q_SHIFT;
                end
            end
            t[i] = e[ENTRY_W-1:0];
        end
        t[1 << tb] = ENTRY_W'(64'd1 << (Q_SHIFT - 1));
        return t;
    endfunction

endpackage

`default_nettype wire

### src/half_life_confidence_decay_unit.sv
// Channel  | Handshake         | Word
// ---------+-------------------+-----------------------------------------------
// input    | s_valid / s_ready | s_base_confidence, s_last_update_ms, s_now_ms
// result   | m_valid / m_ready | m_decayed_confidence, m_decay_applied
// config   | cfg_we            | cfg_wdata -> half_life_ms
//
// One word per cycle while s_ready is high. The pipeline is two front stages, the
// bit-per-stage divider (5 whole + FRAC_BITS fraction stages), four back stages
// and the output register.
// aresetn (synchronous) clears valid bits, the skid stage and half_life_ms.
// On a stall the word goes into a skid register; s_ready drops only once
// the skid register is full, and the pipeline then holds.
`default_nettype none

module half_life_confidence_decay_unit #(
    parameter int FRAC_BITS  = hlcd_pkg::FRAC_BITS_DEF,
    parameter int TABLE_BITS = hlcd_pkg::TABLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // config
    input  wire logic                                cfg_we,
    input  wire logic [hlcd_pkg::HL_W-1:0]           cfg_wdata,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [hlcd_pkg::BASE_W-1:0]         s_base_confidence,
    input  wire logic signed [hlcd_pkg::TS_W-1:0]    s_last_update_ms,
    input  wire logic signed [hlcd_pkg::TS_W-1:0]    s_now_ms,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [hlcd_pkg::BASE_W-1:0]              m_decayed_confidence,
    output logic                                     m_decay_applied
);

    localparam int BW      = hlcd_pkg::BASE_W;
    localparam int TW      = hlcd_pkg::TS_W;
    localparam int HW      = hlcd_pkg::HL_W;
    localparam int EW      = hlcd_pkg::ELAPSED_W;
    localparam int WW      = hlcd_pkg::WHOLE_W;
    localparam int NW      = hlcd_pkg::ENTRY_W;
    localparam int QW      = WW + FRAC_BITS;
    localparam int DLAT    = QW;
    localparam int D       = (FRAC_BITS >= TABLE_BITS) ? FRAC_BITS - TABLE_BITS : 0;
    localparam int UP      = (FRAC_BITS < TABLE_BITS) ? TABLE_BITS - FRAC_BITS : 0;
    localparam int LO_W    = (D > 0) ? D : 1;
    localparam int PROD_W  = NW + LO_W;
    localparam int PM_W    = BW + NW;
    localparam int IW      = hlcd_pkg::TAB_IDX_W;
    localparam int SW      = hlcd_pkg::SHIFT_W;

    localparam hlcd_pkg::tab_t TAB = hlcd_pkg::build_tab(TABLE_BITS);

    // ---------------- config register ----------------
    logic [HW-1:0] hl_reg,   hl_next;
    logic [EW-1:0] hl17_reg, hl17_next;

    always_comb begin
        hl_next   = hl_reg;
        hl17_next = hl17_reg;
        if (cfg_we) begin
            hl_next   = cfg_wdata;
            hl17_next = (EW'(cfg_wdata) << 4) + EW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hl_reg   <= '0;
            hl17_reg <= '0;
        end else begin
            hl_reg   <= hl_next;
            hl17_reg <= hl17_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic skid_v_reg, skid_v_next;
    logic adv;

    assign adv     = !skid_v_reg;
    assign s_ready = adv;

    // ---------------- stage 1: elapsed and pass-through test ----------------
    logic [TW:0]   diff65;
    logic          s1_v_reg;
    logic [TW-1:0] s1_elapsed_reg, s1_elapsed_next;
    logic          s1_apply_reg,   s1_apply_next;
    logic [BW-1:0] s1_base_reg;

    assign diff65          = {s_now_ms[TW-1], s_now_ms}
                           - {s_last_update_ms[TW-1], s_last_update_ms};
    assign s1_elapsed_next = diff65[TW-1:0];
    assign s1_apply_next   = !diff65[TW] && (diff65 != '0) && (hl_reg != '0);

    // ---------------- stage 2: whole part range check ----------------
    logic          s2_v_reg;
    logic [EW-1:0] s2_elapsed_reg;
    hlcd_pkg::side_t s2_side_reg, s2_side_next;

    always_comb begin
        s2_side_next.base  = s1_base_reg;
        s2_side_next.apply = s1_apply_reg;
        s2_side_next.big   = s1_elapsed_reg >= TW'(hl17_reg);
    end

    // ---------------- divider and its sidecar ----------------
    logic [QW-1:0]   quotient;
    logic            dv_reg   [DLAT];
    hlcd_pkg::side_t dside_reg [DLAT];

    hlcd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .en       (adv),
        .dividend (s2_elapsed_reg),
        .divisor  (hl_reg),
        .quotient (quotient)
    );

    // ---------------- stage 3: table read ----------------
    logic [WW-1:0]         whole_q;
    logic [FRAC_BITS-1:0]  frac_q;
    logic [TABLE_BITS-1:0] idx;
    logic [LO_W-1:0]       lo;
    logic [NW-1:0]         e0, e1;

    assign whole_q = quotient[QW-1:FRAC_BITS];
    assign frac_q  = quotient[FRAC_BITS-1:0];

    if (FRAC_BITS > TABLE_BITS) begin : g_interp
        assign idx = frac_q[FRAC_BITS-1 -: TABLE_BITS];
        assign lo  = frac_q[LO_W-1:0];
    end else if (FRAC_BITS == TABLE_BITS) begin : g_exact
        assign idx = frac_q;
        assign lo  = '0;
    end else begin : g_spread
        assign idx = {frac_q, {UP{1'b0}}};
        assign lo  = '0;
    end

    assign e0 = TAB[IW'(idx)];
    assign e1 = TAB[IW'(idx) + IW'(1)];

    logic            s3_v_reg;
    hlcd_pkg::side_t s3_side_reg;
    logic [WW-1:0]   s3_whole_reg;
    logic [NW-1:0]   s3_e0_reg;
    logic [NW-1:0]   s3_diff_reg, s3_diff_next;
    logic [LO_W-1:0] s3_lo_reg;

    assign s3_diff_next = e0 - e1;

    // ---------------- stage 4: slope times low fraction bits ----------------
    logic              s4_v_reg;
    hlcd_pkg::side_t   s4_side_reg;
    logic [WW-1:0]     s4_whole_reg;
    logic [NW-1:0]     s4_e0_reg;
    logic [PROD_W-1:0] s4_prod_reg, s4_prod_next;

    assign s4_prod_next = PROD_W'(s3_diff_reg) * PROD_W'(s3_lo_reg);

    // ---------------- stage 5: interpolated multiplier ----------------
    logic              s5_v_reg;
    hlcd_pkg::side_t   s5_side_reg;
    logic [WW-1:0]     s5_whole_reg;
    logic [NW-1:0]     s5_m_reg, s5_m_next;
    logic [PROD_W-1:0] prod_sh;

    assign prod_sh   = s4_prod_reg >> D;
    assign s5_m_next = s4_e0_reg - prod_sh[NW-1:0];

    // ---------------- stage 6: base times multiplier ----------------
    logic            s6_v_reg;
    hlcd_pkg::side_t s6_side_reg;
    logic [WW-1:0]   s6_whole_reg;
    logic [PM_W-1:0] s6_pm_reg, s6_pm_next;

    assign s6_pm_next = PM_W'(s5_side_reg.base) * PM_W'(s5_m_reg);

    // final shift and select feeding the output register
    logic [SW-1:0]   shamt;
    logic [PM_W-1:0] pm_sh;
    logic [BW-1:0]   res_dec;
    logic            res_app;

    assign shamt   = SW'(hlcd_pkg::Q_SHIFT) + SW'(s6_whole_reg);
    assign pm_sh   = s6_pm_reg >> shamt;
    assign res_app = s6_side_reg.apply;
    assign res_dec = !s6_side_reg.apply ? s6_side_reg.base :
                     s6_side_reg.big    ? '0 : pm_sh[BW-1:0];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            for (int i = 0; i < DLAT; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            dv_reg[0] <= s2_v_reg;
            for (int i = 1; i < DLAT; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
            s3_v_reg <= dv_reg[DLAT-1];
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    // data path registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_elapsed_reg <= s1_elapsed_next;
            s1_apply_reg   <= s1_apply_next;
            s1_base_reg    <= s_base_confidence;

            s2_elapsed_reg <= s1_elapsed_reg[EW-1:0];
            s2_side_reg    <= s2_side_next;

            dside_reg[0] <= s2_side_reg;
            for (int i = 1; i < DLAT; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end

            s3_side_reg  <= dside_reg[DLAT-1];
            s3_whole_reg <= whole_q;
            s3_e0_reg    <= e0;
            s3_diff_reg  <= s3_diff_next;
            s3_lo_reg    <= lo;

            s4_side_reg  <= s3_side_reg;
            s4_whole_reg <= s3_whole_reg;
            s4_e0_reg    <= s3_e0_reg;
            s4_prod_reg  <= s4_prod_next;

            s5_side_reg  <= s4_side_reg;
            s5_whole_reg <= s4_whole_reg;
            s5_m_reg     <= s5_m_next;

            s6_side_reg  <= s5_side_reg;
            s6_whole_reg <= s5_whole_reg;
            s6_pm_reg    <= s6_pm_next;
        end
    end

    // ---------------- output register and skid stage ----------------
    logic          out_v_reg,    out_v_next;
    logic [BW-1:0] out_dec_reg,  out_dec_next;
    logic          out_app_reg,  out_app_next;
    logic [BW-1:0] skid_dec_reg, skid_dec_next;
    logic          skid_app_reg, skid_app_next;

    always_comb begin
        out_v_next    = out_v_reg;
        out_dec_next  = out_dec_reg;
        out_app_next  = out_app_reg;
        skid_v_next   = skid_v_reg;
        skid_dec_next = skid_dec_reg;
        skid_app_next = skid_app_reg;
        if (!out_v_reg || m_ready) begin
            // output slot frees: skid word first, else the pipeline word
            if (skid_v_reg) begin
                out_v_next   = 1'b1;
                out_dec_next = skid_dec_reg;
                out_app_next = skid_app_reg;
                skid_v_next  = 1'b0;
            end else begin
                out_v_next   = s6_v_reg;
                out_dec_next = res_dec;
                out_app_next = res_app;
            end
        end else if (s6_v_reg && !skid_v_reg) begin
            // output held: park the arriving word
            skid_v_next   = 1'b1;
            skid_dec_next = res_dec;
            skid_app_next = res_app;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_dec_reg  <= out_dec_next;
        out_app_reg  <= out_app_next;
        skid_dec_reg <= skid_dec_next;
        skid_app_reg <= skid_app_next;
    end

    assign m_valid              = out_v_reg;
    assign m_decayed_confidence = out_dec_reg;
    assign m_decay_applied      = out_app_reg;

endmodule

`default_nettype wire

### src/hlcd_div.sv
`default_nettype none

// Pipelined restoring divider: whole part of dividend/divisor (below 32),
// then FRAC_BITS truncated fraction bits. One quotient bit per stage.
module hlcd_div #(
    parameter int FRAC_BITS = hlcd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  en,
    input  wire logic [hlcd_pkg::ELAPSED_W-1:0]        dividend,
    input  wire logic [hlcd_pkg::HL_W-1:0]             divisor,
    output logic [hlcd_pkg::WHOLE_W+FRAC_BITS-1:0]     quotient
);

    localparam int QW  = hlcd_pkg::WHOLE_W + FRAC_BITS;
    localparam int EW  = hlcd_pkg::ELAPSED_W;
    localparam int HW  = hlcd_pkg::HL_W;
    localparam int WW  = hlcd_pkg::WHOLE_W;

    logic [EW-1:0] irem_reg [WW];
    logic [HW-1:0] frem_reg [FRAC_BITS-1];
    logic [QW-1:0] q_reg    [QW];

    // Whole part: compare against divisor shifted up, MSB first
    for (genvar k = 0; k < WW; k++) begin : g_int
        localparam int SH = WW - 1 - k;
        logic [EW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [EW-1:0] dsh;
        logic          take;
        logic [EW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_in = dividend;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = irem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign dsh      = EW'(divisor) << SH;
        assign take     = rem_in >= dsh;
        assign rem_next = take ? (rem_in - dsh) : rem_in;

        always_ff @(posedge aclk) begin
            if (en) begin
                irem_reg[k] <= rem_next;
                q_reg[k]    <= {q_in[QW-2:0], take};
            end
        end
    end

    // Fraction: remainder doubles each step, stays below the divisor
    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_frac
        logic [HW:0]   dbl;
        logic [HW:0]   sub;
        logic [QW-1:0] q_in;
        logic          take;

        if (j == 0) begin : g_first
            assign dbl  = {irem_reg[WW-1][HW-1:0], 1'b0};
            assign q_in = q_reg[WW-1];
        end else begin : g_rest
            assign dbl  = {frem_reg[j-1], 1'b0};
            assign q_in = q_reg[WW+j-1];
        end

        assign take = dbl >= {1'b0, divisor};
        assign sub  = dbl - {1'b0, divisor};

        if (j < FRAC_BITS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    frem_reg[j] <= take ? sub[HW-1:0] : dbl[HW-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[WW+j] <= {q_in[QW-2:0], take};
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

`default_nettype wire

### src/hlcd_checker.sv
`default_nettype none

module hlcd_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [hlcd_pkg::BASE_W-1:0] m_decayed_confidence,
    input wire logic                        m_decay_applied
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set right after reset");

    // reset empties the skid stage, so input is open
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("s_ready low right after reset");

    // input closes only behind a stalled, occupied output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("s_ready low without a stalled result word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_decayed_confidence)
                                && $stable(m_decay_applied))
        else $error("result word changed while stalled");

endmodule

bind half_life_confidence_decay_unit hlcd_checker u_hlcd_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_decayed_confidence (m_decayed_confidence),
    .m_decay_applied      (m_decay_applied)
);

`default_nettype wire
